### rtl/size_class_buffer_pool_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the buffer pool RTL.
// Each macro expects clk and arst_n in scope.
// ---------------------------------------------------------------------------
`ifndef SIZE_CLASS_BUFFER_POOL_DEFINES_SVH
`define SIZE_CLASS_BUFFER_POOL_DEFINES_SVH

// same-cycle implication
`define SCBP_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("scbp assertion failed");

// next-cycle implication
`define SCBP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("scbp assertion failed");

`endif

### rtl/scbp_pkg.sv
// ---------------------------------------------------------------------------
// scbp_pkg
// Types, codes and constants of the size class buffer pool.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package scbp_pkg;

	localparam int CLASS_COUNT_DEF     = 7;
	localparam int SLOTS_PER_CLASS_DEF = 128;
	localparam int SIZE_REGS           = 7;
	localparam int QUEUE_DEPTH         = 2;

	localparam int CLS_W        = 3;
	localparam int SLOT_FIELD_W = 7;
	localparam int LEN_W        = 16;
	localparam int STATUS_W     = 2;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 16;
	localparam int OP_W         = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CLASSES_IN_USE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CLASS_SIZE_0   = 3'd1;

	localparam logic [CLS_W-1:0] CLASSES_RESET = 3'd7;

	// commands
	localparam logic CMD_GET     = 1'b0;
	localparam logic CMD_RELEASE = 1'b1;

	// result status
	localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_EMPTY  = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_HEAD   = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_UNUSED = 2'd3;

	// classified operations
	localparam logic [OP_W-1:0] OP_GET    = 2'd0;
	localparam logic [OP_W-1:0] OP_REL    = 2'd1;
	localparam logic [OP_W-1:0] OP_REJECT = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0]         op;
		logic [CLS_W-1:0]        cls;
		logic [SLOT_FIELD_W-1:0] slot;
		logic [LEN_W-1:0]        size;
	} item_t;

	function automatic logic [LEN_W-1:0] size_reset(input int unsigned idx);
		logic [LEN_W-1:0] val;
		case (idx)
			0: val = 16'd128;
			1: val = 16'd256;
			2: val = 16'd512;
			3: val = 16'd1024;
			4: val = 16'd2048;
			5: val = 16'd4096;
			6: val = 16'd8192;
			default: val = '0;
		endcase
		return val;
	endfunction

endpackage

### rtl/scbp_ram.sv
// ---------------------------------------------------------------------------
// scbp_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module scbp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

### rtl/scbp_front.sv
// ---------------------------------------------------------------------------
// scbp_front
// Classifies an incoming item: picks the size class of a get, checks
// the class and slot of a release.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module scbp_front import scbp_pkg::*; #(
	parameter int CLASS_COUNT     = CLASS_COUNT_DEF,
	parameter int SLOTS_PER_CLASS = SLOTS_PER_CLASS_DEF
) (
	input  logic                            command,
	input  logic [LEN_W-1:0]                length_wanted,
	input  logic [CLS_W-1:0]                release_class,
	input  logic [SLOT_FIELD_W-1:0]         release_slot,
	input  logic [CLS_W-1:0]                classes_in_use,
	input  logic [SIZE_REGS-1:0][LEN_W-1:0] class_size,
	output item_t                           item
);

	logic [CLS_W-1:0] active;
	logic [CLS_W-1:0] pick;
	logic             found;

	assign active = (classes_in_use > CLS_W'(CLASS_COUNT)) ? CLS_W'(CLASS_COUNT)
		: classes_in_use;

	// first class that covers the length, else the last class in use
	always_comb begin
		found = 1'b0;
		pick  = '0;
		for (int i = 0; i < SIZE_REGS; i++) begin
			if (!found &&
					(CLS_W'(i) == active - CLS_W'(1) || class_size[i] >= length_wanted)) begin
				pick  = CLS_W'(i);
				found = 1'b1;
			end
		end
	end

	always_comb begin
		item = '0;
		if (command == CMD_GET) begin
			if (active == '0) begin
				item.op = OP_REJECT;
			end else begin
				item.op   = OP_GET;
				item.cls  = pick;
				item.size = class_size[pick];
			end
		end else begin
			if (release_class >= active || int'(release_slot) >= SLOTS_PER_CLASS) begin
				item.op = OP_REJECT;
			end else begin
				item.op   = OP_REL;
				item.cls  = release_class;
				item.slot = release_slot;
			end
		end
	end

endmodule

### rtl/scbp_queue.sv
// ---------------------------------------------------------------------------
// scbp_queue
// Short FIFO of classified items between front and back.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module scbp_queue import scbp_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  full,
	output logic  nonempty,
	input  logic  pop,
	output item_t pop_item
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	item_t             entries_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign full     = (count_q == CNT_W'(QUEUE_DEPTH));
	assign nonempty = (count_q != '0);
	assign pop_item = entries_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= ptr_next(wr_ptr_q);
			if (pop)  rd_ptr_q <= ptr_next(rd_ptr_q);
			case ({push, pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

### rtl/scbp_back.sv
// ---------------------------------------------------------------------------
// scbp_back
// Executes classified items against the free list heads and the link RAM,
// and holds the result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "size_class_buffer_pool_defines.svh"

module scbp_back import scbp_pkg::*; #(
	parameter int CLASS_COUNT     = CLASS_COUNT_DEF,
	parameter int SLOTS_PER_CLASS = SLOTS_PER_CLASS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    nonempty,
	input  item_t                   q_item,
	output logic                    pop,
	output logic                    init_busy,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [STATUS_W-1:0]     status,
	output logic [CLS_W-1:0]        granted_class,
	output logic [SLOT_FIELD_W-1:0] granted_slot,
	output logic [LEN_W-1:0]        granted_size
);

	localparam int SLOT_W = $clog2(SLOTS_PER_CLASS);
	localparam int LINK_W = SLOT_W + 1;
	localparam int DEPTH  = CLASS_COUNT * SLOTS_PER_CLASS;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CIDX_W = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;

	localparam logic [1:0] S_INIT = 2'd0;
	localparam logic [1:0] S_IDLE = 2'd1;
	localparam logic [1:0] S_READ = 2'd2;

	logic [1:0]        state_q;
	logic [ADDR_W-1:0] init_addr_q;
	logic [SLOT_W-1:0] init_slot_q;
	logic              head_valid_q [CLASS_COUNT];
	logic [SLOT_W-1:0] head_slot_q  [CLASS_COUNT];

	logic [CIDX_W-1:0] get_cls_q;
	logic [SLOT_W-1:0] get_slot_q;
	logic [LEN_W-1:0]  get_size_q;
	logic [ADDR_W-1:0] get_addr_q;

	logic                    out_valid_q;
	logic [STATUS_W-1:0]     status_q;
	logic [CLS_W-1:0]        gclass_q;
	logic [SLOT_FIELD_W-1:0] gslot_q;
	logic [LEN_W-1:0]        gsize_q;

	logic              out_free;
	logic [CIDX_W-1:0] cidx;
	logic              hv;
	logic [SLOT_W-1:0] hs;
	logic [SLOT_W-1:0] hs_safe;
	logic [SLOT_W-1:0] rel_slot;
	logic              rel_is_head;
	logic [ADDR_W-1:0] rel_addr;
	logic [ADDR_W-1:0] get_addr;
	logic              init_last_slot;
	logic              go_read;
	logic              rel_push;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [LINK_W-1:0] ram_wdata;
	logic [LINK_W-1:0] ram_rdata;

	logic                    out_load;
	logic [STATUS_W-1:0]     nxt_status;
	logic [CLS_W-1:0]        nxt_class;
	logic [SLOT_FIELD_W-1:0] nxt_slot;
	logic [LEN_W-1:0]        nxt_size;

	assign out_free  = !out_valid_q || !out_stall;
	assign pop       = (state_q == S_IDLE) && nonempty && out_free;
	assign init_busy = (state_q == S_INIT);

	assign cidx        = q_item.cls[CIDX_W-1:0];
	assign hv          = head_valid_q[cidx];
	assign hs          = head_slot_q[cidx];
	assign hs_safe     = (int'(hs) >= SLOTS_PER_CLASS) ? '0 : hs;
	assign rel_slot    = SLOT_W'(q_item.slot);
	assign rel_is_head = hv && (hs == rel_slot);
	assign rel_addr    = ADDR_W'(int'(cidx) * SLOTS_PER_CLASS + int'(rel_slot));
	assign get_addr    = ADDR_W'(int'(cidx) * SLOTS_PER_CLASS + int'(hs_safe));

	assign go_read  = pop && (q_item.op == OP_GET) && hv;
	assign rel_push = pop && (q_item.op == OP_REL) && !rel_is_head;

	assign init_last_slot = (init_slot_q == SLOT_W'(SLOTS_PER_CLASS - 1));

	// link RAM write port: reset sweep, release push, or clearing a popped link
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = init_addr_q;
		ram_wdata = init_last_slot ? '0 : {1'b1, init_slot_q + SLOT_W'(1)};
		unique case (state_q)
			S_INIT: ram_we = 1'b1;
			S_IDLE: begin
				if (rel_push) begin
					ram_we    = 1'b1;
					ram_waddr = rel_addr;
					ram_wdata = {hv, hs};
				end
			end
			S_READ: begin
				ram_we    = 1'b1;
				ram_waddr = get_addr_q;
				ram_wdata = '0;
			end
			default: ram_we = 1'b0;
		endcase
	end

	scbp_ram #(
		.WIDTH(LINK_W),
		.DEPTH(DEPTH)
	) u_link_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(get_addr),
		.rdata(ram_rdata)
	);

	always_comb begin
		out_load   = 1'b0;
		nxt_status = STAT_OK;
		nxt_class  = '0;
		nxt_slot   = '0;
		nxt_size   = '0;
		if (state_q == S_READ) begin
			out_load  = 1'b1;
			nxt_class = CLS_W'(get_cls_q);
			nxt_slot  = SLOT_FIELD_W'(get_slot_q);
			nxt_size  = get_size_q;
		end else if (pop) begin
			case (q_item.op)
				OP_GET: begin
					// head valid: the result waits for the link read
					if (!hv) begin
						out_load   = 1'b1;
						nxt_status = STAT_EMPTY;
						nxt_class  = q_item.cls;
						nxt_size   = q_item.size;
					end
				end
				OP_REL: begin
					out_load   = 1'b1;
					nxt_status = rel_is_head ? STAT_HEAD : STAT_OK;
				end
				default: begin
					out_load   = 1'b1;
					nxt_status = STAT_UNUSED;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			init_addr_q <= '0;
			init_slot_q <= '0;
			out_valid_q <= 1'b0;
			for (int c = 0; c < CLASS_COUNT; c++) begin
				head_valid_q[c] <= 1'b1;
				head_slot_q[c]  <= '0;
			end
		end else begin
			unique case (state_q)
				S_INIT: begin
					init_addr_q <= init_addr_q + ADDR_W'(1);
					init_slot_q <= init_last_slot ? '0 : init_slot_q + SLOT_W'(1);
					if (init_addr_q == ADDR_W'(DEPTH - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (go_read) state_q <= S_READ;
				end
				S_READ: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase

			if (rel_push) begin
				head_valid_q[cidx] <= 1'b1;
				head_slot_q[cidx]  <= rel_slot;
			end else if (state_q == S_READ) begin
				head_valid_q[get_cls_q] <= ram_rdata[LINK_W-1];
				head_slot_q[get_cls_q]  <= ram_rdata[SLOT_W-1:0];
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go_read) begin
			get_cls_q  <= cidx;
			get_slot_q <= hs_safe;
			get_size_q <= q_item.size;
			get_addr_q <= get_addr;
		end
		if (out_load) begin
			status_q <= nxt_status;
			gclass_q <= nxt_class;
			gslot_q  <= nxt_slot;
			gsize_q  <= nxt_size;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign granted_class = gclass_q;
	assign granted_slot  = gslot_q;
	assign granted_size  = gsize_q;

	`SCBP_ASSERT_IMPLY(a_no_pop_busy, state_q != S_IDLE, !pop)
	`SCBP_ASSERT_NEXT(a_read_one_cycle, state_q == S_READ, state_q == S_IDLE)
	`SCBP_ASSERT_IMPLY(a_read_out_empty, state_q == S_READ, !out_valid_q)
	`SCBP_ASSERT_NEXT(a_stalled_result_kept, out_valid_q && out_stall, out_valid_q)

endmodule

### rtl/size_class_buffer_pool.sv
// ---------------------------------------------------------------------------
// size_class_buffer_pool
// Segregated free list buffer pool with up to seven size classes.
// ---------------------------------------------------------------------------
// Request channel (in_valid/in_stall): command, length_wanted, release_class,
// release_slot. A get pops the head slot of the first class whose size covers
// length_wanted (else the last class in use); a release pushes a slot back.
// Result channel (out_valid/out_stall): one result per request with status,
// granted_class, granted_slot and granted_size.
// Config port: cfg_write with cfg_index/cfg_data, index 0 classes_in_use,
// indexes 1..7 class_size_0..6. Write only while the pool is idle.
// Path: a request is written into the queue, then popped by the executor,
// which loads the result register; a get that pops a slot first does the head
// lookup, then the link RAM read updates the head as the result is loaded.
// Throughput: one item per cycle for releases, rejects and empty gets while the result is not stalled; a successful get
// holds off the next item until its link RAM read is done, set by the single link RAM read port. A two-entry queue
// between classifier and executor absorbs short stalls. Reset: the link RAM is initialized in a sweep over all
// CLASS_COUNT * SLOTS_PER_CLASS entries (896 by default) with in_stall high; config writes
// are taken during the sweep. When out_stall is high the result is held and
// the queue fills, then in_stall rises.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module size_class_buffer_pool import scbp_pkg::*; #(
	parameter int CLASS_COUNT     = CLASS_COUNT_DEF,
	parameter int SLOTS_PER_CLASS = SLOTS_PER_CLASS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_write,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic                    command,
	input  logic [LEN_W-1:0]        length_wanted,
	input  logic [CLS_W-1:0]        release_class,
	input  logic [SLOT_FIELD_W-1:0] release_slot,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [STATUS_W-1:0]     status,
	output logic [CLS_W-1:0]        granted_class,
	output logic [SLOT_FIELD_W-1:0] granted_slot,
	output logic [LEN_W-1:0]        granted_size
);

	logic [CLS_W-1:0]                classes_q;
	logic [SIZE_REGS-1:0][LEN_W-1:0] class_size_q;

	item_t front_item;
	item_t q_item;
	logic  q_full;
	logic  q_nonempty;
	logic  q_pop;
	logic  init_busy;
	logic  push;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			classes_q <= CLASSES_RESET;
			for (int i = 0; i < SIZE_REGS; i++) begin
				class_size_q[i] <= size_reset(i);
			end
		end else if (cfg_write) begin
			if (cfg_index == REG_CLASSES_IN_USE) begin
				classes_q <= cfg_data[CLS_W-1:0];
			end else begin
				class_size_q[cfg_index - REG_CLASS_SIZE_0] <= cfg_data;
			end
		end
	end

	assign in_stall = q_full || init_busy;
	assign push     = in_valid && !in_stall;

	scbp_front #(
		.CLASS_COUNT    (CLASS_COUNT),
		.SLOTS_PER_CLASS(SLOTS_PER_CLASS)
	) u_front (
		.command       (command),
		.length_wanted (length_wanted),
		.release_class (release_class),
		.release_slot  (release_slot),
		.classes_in_use(classes_q),
		.class_size    (class_size_q),
		.item          (front_item)
	);

	scbp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_item(front_item),
		.full     (q_full),
		.nonempty (q_nonempty),
		.pop      (q_pop),
		.pop_item (q_item)
	);

	scbp_back #(
		.CLASS_COUNT    (CLASS_COUNT),
		.SLOTS_PER_CLASS(SLOTS_PER_CLASS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.nonempty     (q_nonempty),
		.q_item       (q_item),
		.pop          (q_pop),
		.init_busy    (init_busy),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.granted_class(granted_class),
		.granted_slot (granted_slot),
		.granted_size (granted_size)
	);

endmodule
